// File: hdl/sb2da_pkg.sv
// Package for the signed binary to decimal ASCII converter.
// Holds the digit limits, character codes, divide-by-ten constants and the
// command and status structs shared by the controller and the datapath.
package sb2da_pkg;

  localparam int MAX_DIGITS = 10;
  localparam int DIGIT_BUF  = 10;
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int CNT_W      = $clog2(DIGIT_BUF + 1);
  localparam int IDX_W      = $clog2(DIGIT_BUF);

  localparam int LIMIT_RAW  = (MAX_DIGITS < DIGIT_BUF) ? MAX_DIGITS : DIGIT_BUF;
  localparam int LIMIT_INT  = (LIMIT_RAW < 1) ? 1 : LIMIT_RAW;
  localparam logic [CNT_W-1:0] DIGIT_LIMIT = CNT_W'(LIMIT_INT);

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

  localparam int                 PROD_W      = 2 * VALUE_W;
  localparam int                 DIV10_SHIFT = 35;
  localparam int                 QUOT_W      = PROD_W - DIV10_SHIFT;
  localparam logic [VALUE_W-1:0] DIV10_MAGIC = 32'hCCCC_CCCD;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit_sign;
    logic emit_digit;
  } sb2da_cmd_t;

  typedef struct packed {
    logic div_done;
    logic neg;
    logic last_digit;
  } sb2da_sts_t;

endpackage

// File: hdl/sb2da_ctrl.sv
// Controller state machine of the decimal ASCII converter.
// Sequences load, divide-by-ten steps and character output; uses sb2da_pkg.
module sb2da_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sb2da_pkg::sb2da_sts_t sts,
  output sb2da_pkg::sb2da_cmd_t cmd
);
  import sb2da_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIV, S_SIGN, S_EMIT} state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (sts.div_done) begin
          state_nxt = sts.neg ? S_SIGN : S_EMIT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (sts.last_digit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

// File: hdl/sb2da_datapath.sv
// Datapath of the decimal ASCII converter: magnitude, reciprocal divide by
// ten, digit buffer and the output registers. Uses sb2da_pkg.
module sb2da_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sb2da_pkg::sb2da_cmd_t          cmd,
  output sb2da_pkg::sb2da_sts_t          sts,
  input  logic signed [sb2da_pkg::VALUE_W-1:0] in_value,
  output logic                           out_valid,
  output logic [sb2da_pkg::CHAR_W-1:0]   out_ascii_char,
  output logic                           out_is_last
);
  import sb2da_pkg::*;

  logic [VALUE_W-1:0] mag_r, mag_nxt;
  logic               neg_r;
  logic [QUOT_W-1:0]  quot_r, quot_nxt;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] rem_full;
  logic [DIGIT_W-1:0] digit;
  logic [CNT_W-1:0]   ndig_r;
  logic [CNT_W-1:0]   rd_cnt;
  logic [DIGIT_W-1:0] digit_r [DIGIT_BUF];
  logic               out_valid_r;
  logic [CHAR_W-1:0]  out_char_r;
  logic               out_last_r;

  always_comb begin
    mag_nxt  = in_value[VALUE_W-1] ? (VALUE_W'(0) - $unsigned(in_value)) : $unsigned(in_value);
    prod     = PROD_W'(mag_r) * PROD_W'(DIV10_MAGIC);
    quot_nxt = prod[PROD_W-1:DIV10_SHIFT];
    quot_x10 = VALUE_W'({quot_r, 3'b000}) + VALUE_W'({quot_r, 1'b0});
    rem_full = mag_r - quot_x10;
    digit    = rem_full[DIGIT_W-1:0];
    rd_cnt   = ndig_r - CNT_W'(1);
  end

  assign sts.div_done   = (quot_r == '0) || ((ndig_r + CNT_W'(1)) == DIGIT_LIMIT);
  assign sts.neg        = neg_r;
  assign sts.last_digit = (ndig_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ndig_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_sign | cmd.emit_digit;
      if (cmd.load) begin
        ndig_r <= '0;
      end else if (cmd.div) begin
        ndig_r <= ndig_r + CNT_W'(1);
      end else if (cmd.emit_digit) begin
        ndig_r <= rd_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r <= mag_nxt;
      neg_r <= in_value[VALUE_W-1];
    end else if (cmd.div) begin
      mag_r <= VALUE_W'(quot_r);
    end
    if (cmd.mul) begin
      quot_r <= quot_nxt;
    end
    if (cmd.div) begin
      digit_r[ndig_r[IDX_W-1:0]] <= digit;
    end
    if (cmd.emit_sign) begin
      out_char_r <= ASCII_MINUS;
      out_last_r <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= ASCII_ZERO | CHAR_W'(digit_r[rd_cnt[IDX_W-1:0]]);
      out_last_r <= sts.last_digit;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ascii_char = out_char_r;
  assign out_is_last    = out_last_r;

`ifndef SYNTHESIS
  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |-> (ndig_r != '0))
    else $error("digit emitted from an empty buffer");

  a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div |-> (ndig_r < DIGIT_LIMIT))
    else $error("digit written past the limit");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_ascii_char == ASCII_MINUS && !out_is_last) ||
                   (out_ascii_char >= ASCII_ZERO && out_ascii_char <= 8'h39)))
    else $error("illegal output character");

  a_single_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_last) |=> !out_valid)
    else $error("transfer right after the last character");
`endif

endmodule

// File: hdl/signed_binary_to_decimal_ascii.sv
// Top level of the signed 32-bit integer to decimal ASCII converter.
// Instantiates sb2da_ctrl and sb2da_datapath; uses sb2da_pkg.
//
// A number is transferred in at a rising edge where start is high and busy
// is low; in_value is sampled at that edge. The text leaves one character
// per transfer on out_ascii_char, marked by out_valid for exactly one cycle,
// most significant character first, with a leading '-' for negative values.
// out_is_last is high on the final character. The receiver cannot stall.
// Each digit passes through the shared reciprocal multiplier (multiply,
// then remainder and buffer write), after which the sign and the digits are
// sent one per cycle.
// The next number can be transferred while the last character is shown.
// Synchronous reset on rst_n low returns to idle and drops out_valid.
module signed_binary_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [sb2da_pkg::VALUE_W-1:0] in_value,
  output logic                                 out_valid,
  output logic [sb2da_pkg::CHAR_W-1:0]         out_ascii_char,
  output logic                                 out_is_last
);
  import sb2da_pkg::*;

  sb2da_cmd_t cmd;
  sb2da_sts_t sts;

  sb2da_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  sb2da_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ascii_char (out_ascii_char),
    .out_is_last    (out_is_last)
  );

endmodule
